FILE: rtl/tnsz_pkg.sv
package tnsz_pkg;

  localparam int COORD_W  = 16;
  localparam int D_W      = COORD_W + 1;
  localparam int PR_W     = 2 * D_W;
  localparam int N_W      = 2 * D_W + 1;
  localparam int M_W      = N_W;
  localparam int SPLIT    = (M_W + 1) / 2;
  localparam int MH_W     = M_W - SPLIT;
  localparam int MSQ_W    = 2 * M_W;
  localparam int S_W      = MSQ_W + 2;
  localparam int FRAC_W   = 14;
  localparam int Q_STEPS  = FRAC_W + 1;
  localparam int SCALE_SH = 2 * FRAC_W;
  localparam int P_W      = S_W + 2 * Q_STEPS;
  localparam int QS_W     = S_W + Q_STEPS;
  localparam int R_W      = MSQ_W + SCALE_SH;
  localparam int ESQ_W    = 2 * D_W;
  localparam int ESUM_W   = ESQ_W + 2;
  localparam int THR_W    = 35;
  localparam int CMP_W    = (ESUM_W > THR_W) ? ESUM_W : THR_W;
  localparam int NORM_W   = 16;
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(262144);
  localparam logic [NORM_W-1:0] ONE_Q     = NORM_W'(16384);

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     is_large;
  } tri_out_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic [2:0] ovr;
    logic       nz;
    logic       oversize;
  } side_t;

endpackage

FILE: rtl/tnsz_lane.sv
module tnsz_lane (
  input  logic                              clk,
  input  logic [tnsz_pkg::Q_STEPS-1:0]      en,
  input  logic [tnsz_pkg::S_W-1:0]          s_in,
  input  logic [tnsz_pkg::MSQ_W-1:0]        m2_in,
  output logic [tnsz_pkg::Q_STEPS-1:0]      q
);

  localparam int NS   = tnsz_pkg::Q_STEPS;
  localparam int P_W  = tnsz_pkg::P_W;
  localparam int QS_W = tnsz_pkg::QS_W;
  localparam int S_W  = tnsz_pkg::S_W;
  localparam int R_W  = tnsz_pkg::R_W;

  logic [NS-1:0]   qv [NS];
  logic [P_W-1:0]  pv [NS];
  logic [QS_W-1:0] qs [NS];
  logic [S_W-1:0]  sv [NS];
  logic [R_W-1:0]  rv [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int B = NS - 1 - k;
    logic [NS-1:0]   q_prev;
    logic [P_W-1:0]  p_prev;
    logic [QS_W-1:0] qs_prev;
    logic [S_W-1:0]  s_prev;
    logic [R_W-1:0]  r_prev;
    logic [P_W-1:0]  cand;
    logic            take;

    if (k == 0) begin : g_first
      assign q_prev  = '0;
      assign p_prev  = '0;
      assign qs_prev = '0;
      assign s_prev  = s_in;
      assign r_prev  = R_W'(m2_in) << tnsz_pkg::SCALE_SH;
    end else begin : g_rest
      assign q_prev  = qv[k-1];
      assign p_prev  = pv[k-1];
      assign qs_prev = qs[k-1];
      assign s_prev  = sv[k-1];
      assign r_prev  = rv[k-1];
    end

    assign cand = p_prev + (P_W'(qs_prev) << (B + 1)) + (P_W'(s_prev) << (2 * B));
    assign take = cand <= P_W'(r_prev);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        qv[k] <= take ? (q_prev | (NS'(1) << B)) : q_prev;
        pv[k] <= take ? cand : p_prev;
        qs[k] <= take ? (qs_prev + (QS_W'(s_prev) << B)) : qs_prev;
        sv[k] <= s_prev;
        rv[k] <= r_prev;
      end
    end
  end

  assign q = qv[NS-1];

endmodule

FILE: rtl/triangle_normal_and_size.sv
// Triangle setup unit: takes one triangle per clock (three signed Q8.8 vertices) and returns
// the unit face normal of (v1-v0)x(v2-v0) in signed Q1.14, truncated toward zero (zero vector
// for a degenerate triangle), plus an is_large flag set when the longest squared edge in
// Q16.16 is strictly above the threshold register (reset value 4.0). The pipeline runs the
// edge, cross product and length arithmetic, then the bit-per-stage division by the normal
// length, then one output register. Throughput is one transaction per clock; every stage
// holds under backpressure and bubbles collapse.
// Write the threshold only while no transaction is in flight.
module triangle_normal_and_size (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tnsz_pkg::tri_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tnsz_pkg::tri_out_t              out_data,
  input  logic                            cfg_we,
  input  logic [tnsz_pkg::THR_W-1:0]      cfg_wdata
);

  localparam int NS     = tnsz_pkg::Q_STEPS;
  localparam int NSTG   = 6 + NS + 1;
  localparam int D_W    = tnsz_pkg::D_W;
  localparam int PR_W   = tnsz_pkg::PR_W;
  localparam int N_W    = tnsz_pkg::N_W;
  localparam int M_W    = tnsz_pkg::M_W;
  localparam int SPLIT  = tnsz_pkg::SPLIT;
  localparam int MH_W   = tnsz_pkg::MH_W;
  localparam int MSQ_W  = tnsz_pkg::MSQ_W;
  localparam int S_W    = tnsz_pkg::S_W;
  localparam int ESQ_W  = tnsz_pkg::ESQ_W;
  localparam int ESUM_W = tnsz_pkg::ESUM_W;
  localparam int CMP_W  = tnsz_pkg::CMP_W;
  localparam int NORM_W = tnsz_pkg::NORM_W;

  logic [tnsz_pkg::THR_W-1:0] thr;
  logic [NSTG-1:0]            vld;
  logic [NSTG:0]              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= tnsz_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  assign en[NSTG] = out_ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: edge vectors
  logic signed [tnsz_pkg::COORD_W-1:0] va [3];
  logic signed [tnsz_pkg::COORD_W-1:0] vb [3];
  logic signed [tnsz_pkg::COORD_W-1:0] vc [3];
  logic signed [D_W-1:0] e1 [3];
  logic signed [D_W-1:0] e2 [3];
  logic signed [D_W-1:0] d12 [3];

  assign va[0] = in_data.v0_x;
  assign va[1] = in_data.v0_y;
  assign va[2] = in_data.v0_z;
  assign vb[0] = in_data.v1_x;
  assign vb[1] = in_data.v1_y;
  assign vb[2] = in_data.v1_z;
  assign vc[0] = in_data.v2_x;
  assign vc[1] = in_data.v2_y;
  assign vc[2] = in_data.v2_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]  <= D_W'(vb[i]) - D_W'(va[i]);
        e2[i]  <= D_W'(vc[i]) - D_W'(va[i]);
        d12[i] <= D_W'(vb[i]) - D_W'(vc[i]);
      end
    end
  end

  // stage 2: cross product terms and edge squares
  logic signed [PR_W-1:0] ca [3];
  logic signed [PR_W-1:0] cb [3];
  logic [ESQ_W-1:0] sq1 [3];
  logic [ESQ_W-1:0] sq2 [3];
  logic [ESQ_W-1:0] sq3 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ca[0] <= PR_W'(e1[1]) * PR_W'(e2[2]);
      cb[0] <= PR_W'(e1[2]) * PR_W'(e2[1]);
      ca[1] <= PR_W'(e1[2]) * PR_W'(e2[0]);
      cb[1] <= PR_W'(e1[0]) * PR_W'(e2[2]);
      ca[2] <= PR_W'(e1[0]) * PR_W'(e2[1]);
      cb[2] <= PR_W'(e1[1]) * PR_W'(e2[0]);
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= ESQ_W'(PR_W'(e1[i]) * PR_W'(e1[i]));
        sq2[i] <= ESQ_W'(PR_W'(d12[i]) * PR_W'(d12[i]));
        sq3[i] <= ESQ_W'(PR_W'(e2[i]) * PR_W'(e2[i]));
      end
    end
  end

  // stage 3: normal components and size test
  logic signed [N_W-1:0] nv [3];
  logic                  large3;
  logic [ESUM_W-1:0]     es1, es2, es3;

  assign es1 = ESUM_W'(sq1[0]) + ESUM_W'(sq1[1]) + ESUM_W'(sq1[2]);
  assign es2 = ESUM_W'(sq2[0]) + ESUM_W'(sq2[1]) + ESUM_W'(sq2[2]);
  assign es3 = ESUM_W'(sq3[0]) + ESUM_W'(sq3[1]) + ESUM_W'(sq3[2]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        nv[i] <= N_W'(ca[i]) - N_W'(cb[i]);
      end
      large3 <= (CMP_W'(es1) > CMP_W'(thr)) || (CMP_W'(es2) > CMP_W'(thr)) ||
                (CMP_W'(es3) > CMP_W'(thr));
    end
  end

  // stage 4: magnitudes and split squares
  logic [M_W-1:0]          mg [3];
  logic [2*MH_W-1:0]       pp_hh [3];
  logic [M_W-1:0]          pp_hl [3];
  logic [2*SPLIT-1:0]      pp_ll [3];
  logic [2:0]              sgn4;
  logic                    large4;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign mg[i] = nv[i][N_W-1] ? M_W'(-nv[i]) : M_W'(nv[i]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        pp_hh[i] <= (2*MH_W)'(mg[i][M_W-1:SPLIT]) * (2*MH_W)'(mg[i][M_W-1:SPLIT]);
        pp_hl[i] <= M_W'(mg[i][M_W-1:SPLIT]) * M_W'(mg[i][SPLIT-1:0]);
        pp_ll[i] <= (2*SPLIT)'(mg[i][SPLIT-1:0]) * (2*SPLIT)'(mg[i][SPLIT-1:0]);
        sgn4[i]  <= nv[i][N_W-1];
      end
      large4 <= large3;
    end
  end

  // stage 5: squared components
  logic [MSQ_W-1:0] msq5 [3];
  logic [2:0]       sgn5;
  logic             large5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        msq5[i] <= (MSQ_W'(pp_hh[i]) << (2 * SPLIT)) + (MSQ_W'(pp_hl[i]) << (SPLIT + 1)) +
                   MSQ_W'(pp_ll[i]);
      end
      sgn5   <= sgn4;
      large5 <= large4;
    end
  end

  // stage 6: squared length
  logic [S_W-1:0]   ssum;
  logic [S_W-1:0]   s6;
  logic [MSQ_W-1:0] msq6 [3];
  tnsz_pkg::side_t  side6;

  assign ssum = S_W'(msq5[0]) + S_W'(msq5[1]) + S_W'(msq5[2]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6 <= ssum;
      for (int i = 0; i < 3; i++) begin
        msq6[i]      <= msq5[i];
        side6.ovr[i] <= S_W'(msq5[i]) >= ssum;
      end
      side6.sgn      <= sgn5;
      side6.nz       <= ssum != '0;
      side6.oversize <= large5;
    end
  end

  // division by the length, one quotient bit per stage
  logic [NS-1:0]   qo [3];
  tnsz_pkg::side_t side [NS];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tnsz_lane u_lane (
      .clk   (clk),
      .en    (en[6 +: NS]),
      .s_in  (s6),
      .m2_in (msq6[i]),
      .q     (qo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en[6]) side[0] <= side6;
    for (int k = 1; k < NS; k++) begin
      if (en[6+k]) side[k] <= side[k-1];
    end
  end

  // output register
  logic [NORM_W-1:0] umag [3];
  logic [NORM_W-1:0] nrm  [3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    assign umag[i] = side[NS-1].ovr[i] ? tnsz_pkg::ONE_Q : NORM_W'(qo[i]);
    assign nrm[i]  = !side[NS-1].nz ? '0 :
                     (side[NS-1].sgn[i] ? NORM_W'(-umag[i]) : umag[i]);
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_data.normal_x <= nrm[0];
      out_data.normal_y <= nrm[1];
      out_data.normal_z <= nrm[2];
      out_data.is_large <= side[NS-1].oversize;
    end
  end

  a_norm_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
                   out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384 &&
                   out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384))
    else $error("normal component out of range");

  a_degenerate : assert property (@(posedge clk) disable iff (rst)
    (en[NSTG-1] && vld[NSTG-2] && !side[NS-1].nz) |=>
      (out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0))
    else $error("degenerate triangle gave a nonzero normal");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input stalled with a bubble in the pipeline");

  a_quot_bound : assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-2] && side[NS-1].nz) |->
      (qo[0] <= NS'(16384) && qo[1] <= NS'(16384) && qo[2] <= NS'(16384)))
    else $error("quotient above one");

endmodule
